// ===== rtl/crsi_pkg.sv =====
// Shared constants, coefficient record and reciprocal tables for the
// Catmull-Rom segment interpolator. No dependencies.
package crsi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_SAMPLES = 64;
    localparam int N_RESET     = 16;

    localparam int PW  = 32;                      // control point and sample width
    localparam int NW  = 7;                       // samples_per_segment register width
    localparam int JW  = $clog2(MAX_SAMPLES);     // sample index width
    localparam int TW  = FRAC_BITS;               // t fraction width
    localparam int QW  = FRAC_BITS + 1;           // per-step quotient width
    localparam int DW  = PW + 1;                  // width of point differences
    localparam int C1W = PW + 1;
    localparam int C2W = PW + 4;
    localparam int C3W = PW + 3;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);

    localparam int unsigned One = 2 ** FRAC_BITS;

    // floor(2^F / n) and 2^F mod n, entry n-1 for n = 1..MAX_SAMPLES
    localparam int unsigned RECIP_Q [MAX_SAMPLES] = '{
        One/1,  One/2,  One/3,  One/4,  One/5,  One/6,  One/7,  One/8,
        One/9,  One/10, One/11, One/12, One/13, One/14, One/15, One/16,
        One/17, One/18, One/19, One/20, One/21, One/22, One/23, One/24,
        One/25, One/26, One/27, One/28, One/29, One/30, One/31, One/32,
        One/33, One/34, One/35, One/36, One/37, One/38, One/39, One/40,
        One/41, One/42, One/43, One/44, One/45, One/46, One/47, One/48,
        One/49, One/50, One/51, One/52, One/53, One/54, One/55, One/56,
        One/57, One/58, One/59, One/60, One/61, One/62, One/63, One/64
    };

    localparam int unsigned RECIP_R [MAX_SAMPLES] = '{
        One%1,  One%2,  One%3,  One%4,  One%5,  One%6,  One%7,  One%8,
        One%9,  One%10, One%11, One%12, One%13, One%14, One%15, One%16,
        One%17, One%18, One%19, One%20, One%21, One%22, One%23, One%24,
        One%25, One%26, One%27, One%28, One%29, One%30, One%31, One%32,
        One%33, One%34, One%35, One%36, One%37, One%38, One%39, One%40,
        One%41, One%42, One%43, One%44, One%45, One%46, One%47, One%48,
        One%49, One%50, One%51, One%52, One%53, One%54, One%55, One%56,
        One%57, One%58, One%59, One%60, One%61, One%62, One%63, One%64
    };

    typedef struct packed {
        logic signed [C1W-1:0] c1;
        logic signed [C2W-1:0] c2;
        logic signed [C3W-1:0] c3;
        logic signed [PW-1:0]  p1;
    } t_coef;

endpackage

// ===== rtl/crsi_front.sv =====
// Front end: accepts control points and forms the cubic coefficients in two
// registered steps. Depends on crsi_pkg.
module crsi_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic signed [crsi_pkg::PW-1:0]    i_p0,
    input  logic signed [crsi_pkg::PW-1:0]    i_p1,
    input  logic signed [crsi_pkg::PW-1:0]    i_p2,
    input  logic signed [crsi_pkg::PW-1:0]    i_p3,
    output logic                              o_valid,
    input  logic                              i_ready,
    output crsi_pkg::t_coef                   o_coef
);

    logic                                r_a_valid;
    logic signed [crsi_pkg::C1W-1:0]     r_a_c1;
    logic signed [crsi_pkg::DW-1:0]      r_a_u;   // p1 - p2
    logic signed [crsi_pkg::DW-1:0]      r_a_v;   // p3 - p0
    logic signed [crsi_pkg::DW-1:0]      r_a_w;   // p0 - p1
    logic signed [crsi_pkg::PW-1:0]      r_a_p1;

    logic                                r_b_valid;
    crsi_pkg::t_coef                     r_b_coef;
    crsi_pkg::t_coef                     n_b_coef;

    logic adv_a;
    logic adv_b;

    assign adv_b  = !r_b_valid || i_ready;
    assign adv_a  = !r_a_valid || adv_b;
    assign o_full = !adv_a;

    // c3 = 3u + v, c2 = w - v - 4u
    always_comb begin
        n_b_coef.c1 = r_a_c1;
        n_b_coef.p1 = r_a_p1;
        n_b_coef.c3 = (crsi_pkg::C3W'(r_a_u) <<< 1) + crsi_pkg::C3W'(r_a_u)
                    + crsi_pkg::C3W'(r_a_v);
        n_b_coef.c2 = crsi_pkg::C2W'(r_a_w) - crsi_pkg::C2W'(r_a_v)
                    - (crsi_pkg::C2W'(r_a_u) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_valid <= i_push;
            end
            if (adv_b) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (adv_a && i_push) begin
            r_a_c1 <= crsi_pkg::C1W'(i_p2) - crsi_pkg::C1W'(i_p0);
            r_a_u  <= crsi_pkg::DW'(i_p1) - crsi_pkg::DW'(i_p2);
            r_a_v  <= crsi_pkg::DW'(i_p3) - crsi_pkg::DW'(i_p0);
            r_a_w  <= crsi_pkg::DW'(i_p0) - crsi_pkg::DW'(i_p1);
            r_a_p1 <= i_p1;
        end
        if (adv_b && r_a_valid) begin
            r_b_coef <= n_b_coef;
        end
    end

    assign o_valid = r_b_valid;
    assign o_coef  = r_b_coef;

endmodule

// ===== rtl/crsi_coef_queue.sv =====
// Short queue of coefficient records between the front and back ends.
// Depends on crsi_pkg.
module crsi_coef_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crsi_pkg::t_coef  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output crsi_pkg::t_coef  o_data
);

    crsi_pkg::t_coef             r_mem [crsi_pkg::CQ_DEPTH];
    logic [crsi_pkg::CQ_PW-1:0]  r_wr;
    logic [crsi_pkg::CQ_PW-1:0]  r_rd;
    logic [crsi_pkg::CQ_PW:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (crsi_pkg::CQ_PW+1)'(crsi_pkg::CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/crsi_back.sv =====
// Back end: segment length register, sample sequencer, Horner pipeline and
// result queue. Depends on crsi_pkg.
module crsi_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crsi_pkg::NW-1:0]           i_cfg_data,
    input  logic                              i_q_empty,
    input  crsi_pkg::t_coef                   i_q_data,
    output logic                              o_q_pop,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic signed [crsi_pkg::PW-1:0]    o_value,
    output logic [crsi_pkg::JW-1:0]           o_index,
    output logic                              o_last
);

    localparam int F   = crsi_pkg::FRAC_BITS;
    localparam int M1W = crsi_pkg::C3W + crsi_pkg::TW + 1;
    localparam int A1W = crsi_pkg::C2W + 1;
    localparam int M2W = A1W + crsi_pkg::TW + 1;
    localparam int A2W = M2W - F;
    localparam int M3W = A2W + crsi_pkg::TW + 1;
    localparam int A3W = M3W - F + 1;
    localparam int VW  = A3W - 1;
    localparam int NW  = crsi_pkg::NW;
    localparam int JW  = crsi_pkg::JW;
    localparam int TW  = crsi_pkg::TW;
    localparam int QW  = crsi_pkg::QW;
    localparam int PW  = crsi_pkg::PW;

    typedef struct packed {
        logic signed [M1W-1:0]           m1;
        logic signed [crsi_pkg::C2W-1:0] c2;
        logic signed [crsi_pkg::C1W-1:0] c1;
        logic signed [PW-1:0]            p1;
        logic [TW-1:0]                   t;
        logic [JW-1:0]                   j;
        logic                            last;
    } t_s1;

    typedef struct packed {
        logic signed [M2W-1:0]           m2;
        logic signed [crsi_pkg::C1W-1:0] c1;
        logic signed [PW-1:0]            p1;
        logic [TW-1:0]                   t;
        logic [JW-1:0]                   j;
        logic                            last;
    } t_s2;

    typedef struct packed {
        logic signed [M3W-1:0] m3;
        logic signed [PW-1:0]  p1;
        logic [JW-1:0]         j;
        logic                  last;
    } t_s3;

    typedef struct packed {
        logic signed [PW-1:0] value;
        logic [JW-1:0]        index;
        logic                 last;
    } t_sample;

    function automatic logic [NW-1:0] clamp_n(input logic [NW-1:0] v);
        logic [NW-1:0] r;
        if (v == '0) begin
            r = NW'(1);
        end else if (v > NW'(crsi_pkg::MAX_SAMPLES)) begin
            r = NW'(crsi_pkg::MAX_SAMPLES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // segment length and per-step quotient / remainder
    logic [NW-1:0] r_n;
    logic [QW-1:0] r_q;
    logic [NW-1:0] r_r;
    logic [NW-1:0] n_n;

    // sequencer
    logic                  r_busy;
    crsi_pkg::t_coef       r_cur;
    logic [JW-1:0]         r_j;
    logic [TW-1:0]         r_t;
    logic [NW-1:0]         r_rem;

    logic                  issue;
    logic                  seq_last;
    logic                  load;
    logic [NW-1:0]         rem_sum;
    logic                  carry;
    logic [NW-1:0]         n_rem;
    logic [QW-1:0]         t_sum;

    // pipeline
    logic                  r_s1_valid;
    logic                  r_s2_valid;
    logic                  r_s3_valid;
    t_s1                   r_s1;
    t_s2                   r_s2;
    t_s3                   r_s3;
    logic signed [A1W-1:0] n_a1;
    logic signed [A2W-1:0] n_a2;
    logic signed [A3W-1:0] n_a3;
    logic signed [VW-1:0]  n_v;
    t_sample               n_sample;

    // result queue
    t_sample               r_oq [crsi_pkg::OQ_DEPTH];
    logic [crsi_pkg::OQ_PW-1:0] r_oq_wr;
    logic [crsi_pkg::OQ_PW-1:0] r_oq_rd;
    logic [crsi_pkg::OQ_PW:0]   r_oq_count;
    logic [crsi_pkg::OQ_PW+1:0] used;
    logic                  credit_ok;
    logic                  oq_pop;

    assign n_n = clamp_n(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= NW'(crsi_pkg::N_RESET);
            r_q <= QW'(crsi_pkg::RECIP_Q[crsi_pkg::N_RESET-1]);
            r_r <= NW'(crsi_pkg::RECIP_R[crsi_pkg::N_RESET-1]);
        end else if (i_cfg_we) begin
            r_n <= n_n;
            r_q <= QW'(crsi_pkg::RECIP_Q[JW'(n_n - NW'(1))]);
            r_r <= NW'(crsi_pkg::RECIP_R[JW'(n_n - NW'(1))]);
        end
    end

    // reserve a result slot for every sample still in the pipeline
    assign used      = (crsi_pkg::OQ_PW+2)'(r_oq_count)
                     + (crsi_pkg::OQ_PW+2)'(r_s1_valid)
                     + (crsi_pkg::OQ_PW+2)'(r_s2_valid)
                     + (crsi_pkg::OQ_PW+2)'(r_s3_valid);
    assign credit_ok = (used < (crsi_pkg::OQ_PW+2)'(crsi_pkg::OQ_DEPTH));

    assign issue    = r_busy && credit_ok;
    assign seq_last = ({1'b0, r_j} == (r_n - NW'(1)));
    // take the next segment as the current one issues its final sample
    assign load     = !i_q_empty && (!r_busy || (issue && seq_last));
    assign o_q_pop  = load;

    // t advances by floor(2^F/n) plus a carry out of the remainder
    assign rem_sum = r_rem + r_r;
    assign carry   = (rem_sum >= r_n);
    assign n_rem   = carry ? (rem_sum - r_n) : rem_sum;
    assign t_sum   = {1'b0, r_t} + r_q + QW'(carry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (issue && seq_last) begin
            r_busy <= 1'b0;
        end
        if (load) begin
            r_cur <= i_q_data;
            r_j   <= '0;
            r_t   <= '0;
            r_rem <= '0;
        end else if (issue) begin
            r_j   <= r_j + 1'b1;
            r_t   <= TW'(t_sum);
            r_rem <= n_rem;
        end
    end

    // Horner: a = c3; a = floor(a*t) + c2; a = floor(a*t) + c1; a = floor(a*t) + 2p1
    always_comb begin
        n_a1 = A1W'(r_s1.m1 >>> F) + A1W'(r_s1.c2);
        n_a2 = A2W'(r_s2.m2 >>> F) + A2W'(r_s2.c1);
        n_a3 = A3W'(r_s3.m3 >>> F) + A3W'($signed({r_s3.p1, 1'b0}));
        n_v  = VW'(n_a3 >>> 1);
        if (n_v[VW-1:PW-1] == '0 || n_v[VW-1:PW-1] == '1) begin
            n_sample.value = n_v[PW-1:0];
        end else if (n_v[VW-1]) begin
            n_sample.value = {1'b1, {(PW-1){1'b0}}};
        end else begin
            n_sample.value = {1'b0, {(PW-1){1'b1}}};
        end
        n_sample.index = r_s3.j;
        n_sample.last  = r_s3.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
        r_s1.m1   <= M1W'(r_cur.c3) * M1W'($signed({1'b0, r_t}));
        r_s1.c2   <= r_cur.c2;
        r_s1.c1   <= r_cur.c1;
        r_s1.p1   <= r_cur.p1;
        r_s1.t    <= r_t;
        r_s1.j    <= r_j;
        r_s1.last <= seq_last;

        r_s2.m2   <= M2W'(n_a1) * M2W'($signed({1'b0, r_s1.t}));
        r_s2.c1   <= r_s1.c1;
        r_s2.p1   <= r_s1.p1;
        r_s2.t    <= r_s1.t;
        r_s2.j    <= r_s1.j;
        r_s2.last <= r_s1.last;

        r_s3.m3   <= M3W'(n_a2) * M3W'($signed({1'b0, r_s2.t}));
        r_s3.p1   <= r_s2.p1;
        r_s3.j    <= r_s2.j;
        r_s3.last <= r_s2.last;
    end

    assign o_empty = (r_oq_count == '0);
    assign oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_s3_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            case ({r_s3_valid, oq_pop})
                2'b10:   r_oq_count <= r_oq_count + 1'b1;
                2'b01:   r_oq_count <= r_oq_count - 1'b1;
                default: r_oq_count <= r_oq_count;
            endcase
        end
        if (r_s3_valid) begin
            r_oq[r_oq_wr] <= n_sample;
        end
    end

    assign o_value = r_oq[r_oq_rd].value;
    assign o_index = r_oq[r_oq_rd].index;
    assign o_last  = r_oq[r_oq_rd].last;

endmodule

// ===== rtl/catmull_rom_segment_interpolator.sv =====
// Top level of the Catmull-Rom segment interpolator.
// Depends on crsi_pkg, crsi_front, crsi_coef_queue and crsi_back.

// Each item (four Q16.16 control points) yields N samples, N being the
// segment length register clamped to 1..64 (0 reads as 1). The back-end
// sequencer issues one sample per clock while the result queue has room, and
// loads the next segment as it issues the last sample of the current one; the
// coefficient queue lets the front take new items while the current segment
// is still being sampled. On an idle block an accepted item reaches the
// result ports through the second coefficient step, the queue write, a load
// of the sequencer, three Horner stages and the result queue write. There
// is no clearing pass after reset. Write the segment length only when the
// block is idle.
module catmull_rom_segment_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crsi_pkg::NW-1:0]           i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_before,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_start,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_end,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_after,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [crsi_pkg::PW-1:0]    o_sample_value,
    output logic [crsi_pkg::JW-1:0]           o_sample_index,
    output logic                              o_last_sample
);

    logic            front_valid;
    logic            cq_full;
    logic            cq_empty;
    logic            cq_pop;
    crsi_pkg::t_coef front_coef;
    crsi_pkg::t_coef cq_data;

    crsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_p0    (i_point_before),
        .i_p1    (i_point_start),
        .i_p2    (i_point_end),
        .i_p3    (i_point_after),
        .o_valid (front_valid),
        .i_ready (!cq_full),
        .o_coef  (front_coef)
    );

    crsi_coef_queue u_coef_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_coef),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_data  (cq_data)
    );

    crsi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (cq_empty),
        .i_q_data   (cq_data),
        .o_q_pop    (cq_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_value    (o_sample_value),
        .o_index    (o_sample_index),
        .o_last     (o_last_sample)
    );

endmodule

// ===== rtl/crsi_checker.sv =====
// Port-level checks for the Catmull-Rom segment interpolator, bound to the
// top level. Depends on crsi_pkg.
module crsi_port_checks (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crsi_pkg::NW-1:0]           i_cfg_data,
    input  logic                              push,
    input  logic                              full,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_before,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_start,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_end,
    input  logic signed [crsi_pkg::PW-1:0]    i_point_after,
    input  logic                              empty,
    input  logic                              pop,
    input  logic signed [crsi_pkg::PW-1:0]    o_sample_value,
    input  logic [crsi_pkg::JW-1:0]           o_sample_index,
    input  logic                              o_last_sample
);

    // index expected on the next item taken from the result side
    logic [crsi_pkg::JW-1:0] r_exp_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_index <= '0;
        end else if (pop && !empty) begin
            r_exp_index <= o_last_sample ? '0 : o_sample_index + 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty |-> o_sample_index == r_exp_index)
        else $error("sample index out of sequence");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_sample_value)
                           && $stable(o_sample_index) && $stable(o_last_sample))
        else $error("waiting result changed before it was taken");

endmodule

bind catmull_rom_segment_interpolator crsi_port_checks u_port_checks (.*);

// ===== tb/crsi_checker.sv =====
// Checker for the Catmull-Rom segment interpolator: watches the config, item and
// sample channels, predicts the samples of each segment and compares them in order.
// Depends on crsi_pkg for widths and the reset segment length.
module crsi_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crsi_pkg::NW-1:0]         i_cfg_data,
    input  logic                            push,
    input  logic                            full,
    input  logic signed [crsi_pkg::PW-1:0]  i_point_before,
    input  logic signed [crsi_pkg::PW-1:0]  i_point_start,
    input  logic signed [crsi_pkg::PW-1:0]  i_point_end,
    input  logic signed [crsi_pkg::PW-1:0]  i_point_after,
    input  logic                            empty,
    input  logic                            pop,
    input  logic signed [crsi_pkg::PW-1:0]  i_sample_value,
    input  logic [crsi_pkg::JW-1:0]         i_sample_index,
    input  logic                            i_last_sample,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_segments_seen,
    output int                              o_samples_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = crsi_pkg::PW;
    localparam int JW = crsi_pkg::JW;
    localparam int NW = crsi_pkg::NW;
    localparam int FB = crsi_pkg::FRAC_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [PW-1:0] value;
        logic [JW-1:0]        index;
        logic                 last;
    } t_sample;

    t_sample        due_samples[$];
    logic [NW-1:0]  seg_len;
    int             reported;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_segments_seen = 0;
        o_samples_seen  = 0;
        reported        = 0;
        seg_len         = NW'(crsi_pkg::N_RESET);
    end

    function automatic logic signed [PW-1:0] clip32(input longint signed v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[PW-1:0];
    endfunction

    task automatic predict_segment(input logic signed [PW-1:0] p0, p1, p2, p3);
        longint signed q0, q1, q2, q3;
        longint signed c1, c2, c3, acc, t;
        int            n;
        t_sample       s;
        q0 = p0;
        q1 = p1;
        q2 = p2;
        q3 = p3;
        c1 = q2 - q0;
        c2 = 2 * q0 - 5 * q1 + 4 * q2 - q3;
        c3 = -q0 + 3 * q1 - 3 * q2 + q3;
        // a length of zero reads as one, anything beyond the maximum saturates
        n = int'(seg_len);
        if (n < 1)
            n = 1;
        if (n > crsi_pkg::MAX_SAMPLES)
            n = crsi_pkg::MAX_SAMPLES;
        for (int j = 0; j < n; j++) begin
            t   = (longint'(j) << FB) / n;
            acc = c3;
            acc = ((acc * t) >>> FB) + c2;
            acc = ((acc * t) >>> FB) + c1;
            acc = ((acc * t) >>> FB) + 2 * q1;
            acc = acc >>> 1;
            s.value = clip32(acc);
            s.index = JW'(j);
            s.last  = (j == n - 1);
            due_samples.insert(due_samples.size(), s);
        end
    endtask

    task automatic check_sample();
        t_sample want;
        if (due_samples.size() == 0) begin
            o_fail_count++;
            if (reported < MAX_REPORTS)
                $display("%0t: unexpected sample value %h index %0d last %0b",
                         $realtime, i_sample_value, i_sample_index, i_last_sample);
            reported++;
            return;
        end
        want = due_samples[0];
        due_samples.delete(0);
        if (want.value !== i_sample_value || want.index !== i_sample_index ||
            want.last !== i_last_sample) begin
            o_fail_count++;
            if (reported < MAX_REPORTS)
                $display("%0t: sample mismatch: expected value %h index %0d last %0b, %s",
                         $realtime, want.value, want.index, want.last, "got");
            if (reported < MAX_REPORTS)
                $display("    actual value %h index %0d last %0b",
                         i_sample_value, i_sample_index, i_last_sample);
            reported++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_len = NW'(crsi_pkg::N_RESET);
            due_samples.delete();
        end else begin
            if (i_cfg_we)
                seg_len = i_cfg_data;
            // compare before predicting: a sample can never belong to an item taken this edge
            if (pop && !empty) begin
                o_samples_seen++;
                check_sample();
            end
            if (push && !full) begin
                o_segments_seen++;
                predict_segment(i_point_before, i_point_start, i_point_end, i_point_after);
            end
        end
        o_pending = due_samples.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the interpolator testbench: clock, reset, item and config stimulus,
// random pop pacing, watchdog and verdict. Depends on crsi_pkg, the block and crsi_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW         = crsi_pkg::PW;
    localparam int NW         = crsi_pkg::NW;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 150;
    localparam int N_PHASES   = 10;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [NW-1:0]        i_cfg_data     = '0;
    logic                 push           = 1'b0;
    logic                 full;
    logic signed [PW-1:0] i_point_before = '0;
    logic signed [PW-1:0] i_point_start  = '0;
    logic signed [PW-1:0] i_point_end    = '0;
    logic signed [PW-1:0] i_point_after  = '0;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic signed [PW-1:0] o_sample_value;
    logic [crsi_pkg::JW-1:0] o_sample_index;
    logic                 o_last_sample;

    int fail_count, pending, segments_seen, samples_seen;
    bit quiet       = 1'b0;
    bit want_stall  = 1'b0;
    bit stall_done  = 1'b0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    catmull_rom_segment_interpolator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_point_before (i_point_before),
        .i_point_start  (i_point_start),
        .i_point_end    (i_point_end),
        .i_point_after  (i_point_after),
        .empty          (empty),
        .pop            (pop),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_last_sample  (o_last_sample)
    );

    crsi_checker u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_point_before  (i_point_before),
        .i_point_start   (i_point_start),
        .i_point_end     (i_point_end),
        .i_point_after   (i_point_after),
        .empty           (empty),
        .pop             (pop),
        .i_sample_value  (o_sample_value),
        .i_sample_index  (o_sample_index),
        .i_last_sample   (o_last_sample),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_segments_seen (segments_seen),
        .o_samples_seen  (samples_seen)
    );

    // end the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random pop bursts, one long hold-off when asked, steady pop when quiet
    initial begin : receiver
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (want_stall && !stall_done) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                stall_done = 1'b1;
            end else if (burst > 0) begin
                burst--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 3) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic signed [PW-1:0] pick_point();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return PW'($signed($urandom_range(0, 2097151)) - 1048576);
            3:       return 32'sh7FFF_0000 + PW'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // enter and leave at a falling edge; push stays high across back-to-back items
    task automatic send_item(input logic signed [PW-1:0] p0, p1, p2, p3);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_point_before <= p0;
        i_point_start  <= p1;
        i_point_end    <= p2;
        i_point_after  <= p3;
        do
            @(posedge i_clk);
        while (full);
        @(negedge i_clk);
    endtask

    // a smooth run of points most of the time, noise and extremes otherwise
    task automatic send_random_item();
        longint signed base, step;
        if ($urandom_range(0, 9) < 6) begin
            base = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000;
            step = $signed($urandom_range(0, 2097151)) - 1048576;
            send_item(PW'(base), PW'(base + step),
                      PW'(base + 2 * step + $signed($urandom_range(0, 8191)) - 4096),
                      PW'(base + 3 * step + $signed($urandom_range(0, 8191)) - 4096));
        end else begin
            send_item(pick_point(), pick_point(), pick_point(), pick_point());
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_seg_len(input int n);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= NW'(n);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int settings [N_PHASES];
        int n, count;
        settings = '{1, 64, 0, 127, 65, 2, 5, 16, 3, -1};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner segments at the reset length
        send_item(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
        send_item(32'sh0000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_item(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        send_item(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 32'sh0000_0004);
        send_item(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_item(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_item(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);

        // one segment length per phase, written only once the block has drained
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            n = (settings[ph] < 0) ? $urandom_range(0, 127) : settings[ph];
            write_seg_len(n);
            if (ph == N_PHASES - 1)
                quiet = 1'b1;
            if (n == 5)
                want_stall = 1'b1;
            count = (n >= 32) ? 10 : 25;
            for (int k = 0; k < count; k++)
                send_random_item();
        end

        drain();
        $display("Covered %0d segments and %0d samples over %0d segment lengths,",
                 segments_seen, samples_seen, N_PHASES + 1);
        $display("including zero, the maximum, values beyond it and a long output stall.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/crsi_pkg.sv
rtl/crsi_front.sv
rtl/crsi_coef_queue.sv
rtl/crsi_back.sv
rtl/catmull_rom_segment_interpolator.sv
rtl/crsi_checker.sv
tb/crsi_checker.sv
tb/testbench.sv
